### sv/rfse_pkg.sv
package rfse_pkg;

	// Pressed-button codes after inverting the active-low pins
	localparam logic [3:0] BTN_MASK  = 4'b1111;
	localparam logic [3:0] BTN_UP    = 4'b0001;
	localparam logic [3:0] BTN_RIGHT = 4'b0010;
	localparam logic [3:0] BTN_LEFT  = 4'b0100;
	localparam logic [3:0] BTN_DOWN  = 4'b1000;

	// Cursor positions
	localparam logic [2:0] CUR_EXIT    = 3'd0;
	localparam logic [2:0] CUR_SECONDS = 3'd1;
	localparam logic [2:0] CUR_MINUTES = 3'd2;
	localparam logic [2:0] CUR_HOURS   = 3'd3;
	localparam logic [2:0] CUR_WEEKDAY = 3'd4;
	localparam logic [2:0] CUR_DAY     = 3'd5;
	localparam logic [2:0] CUR_MONTH   = 3'd6;
	localparam logic [2:0] CUR_YEAR    = 3'd7;

	localparam logic [5:0]  SEC_TOP     = 6'd59;
	localparam logic [4:0]  HOUR_TOP    = 5'd23;
	localparam logic [2:0]  WEEKDAY_TOP = 3'd7;
	localparam logic [4:0]  DAY_TOP     = 5'd31;
	localparam logic [3:0]  MONTH_TOP   = 4'd12;
	localparam logic [11:0] YEAR_BASE   = 12'd2000;
	localparam logic [11:0] YEAR_TOP    = 12'd2099;

	typedef struct packed {
		logic [3:0]  buttons_raw;
		logic [5:0]  cur_seconds;
		logic [5:0]  cur_minutes;
		logic [4:0]  cur_hours;
		logic [2:0]  cur_weekday;
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [11:0] cur_year;
	} rfse_poll_t;

	typedef struct packed {
		logic [2:0] cursor_position;
		logic       write_strobe;
		logic [2:0] write_index;
		logic [6:0] write_value;
		logic       exit_request;
	} rfse_result_t;

endpackage

### sv/rfse_if.sv
interface rfse_poll_if import rfse_pkg::*; ();
	logic       valid;
	logic       ready;
	rfse_poll_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rfse_result_if import rfse_pkg::*; ();
	logic         valid;
	logic         ready;
	rfse_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/rtc_field_setup_editor_top.sv
// Setup editor for a real-time clock, one poll per transaction.
// poll channel: active-low button pins plus the clock fields read back.
// result channel: cursor after the poll, an optional register write
// (strobe, index 0 sec .. 6 year, value; year as year minus 2000) and an
// exit request when up or down is pressed at cursor 0.
// Every poll gives exactly one result, in order.
// A poll is registered in the input register on acceptance; its result is
// then registered in the result register and offered on the result channel.
// Throughput: one poll per cycle while the result receiver is ready; the
// decode, compare and increment logic sits between the two registers.
// When the result receiver stalls, one result waits in the result register
// and one poll in the input register; poll.ready drops only when both are
// full. The cursor register advances as a poll moves into the result stage.
// Reset (arst_n low) clears the cursor to 0 and empties both stages.
module rtc_field_setup_editor_top import rfse_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	rfse_poll_if.sink      poll,
	rfse_result_if.source  result
);

	logic         valid_s1;
	rfse_poll_t   poll_s1;
	logic         valid_s2;
	rfse_result_t result_s2;
	logic [2:0]   cursor_q;

	logic         adv_s1;
	logic [3:0]   pressed;
	logic         up;
	logic         down;
	logic [2:0]   cursor_nxt;
	logic [6:0]   field_val;
	logic [11:0]  year_clamp;
	logic [11:0]  year_new;
	logic [11:0]  year_off;
	rfse_result_t res;

	assign adv_s1     = !valid_s2 || result.ready;
	assign poll.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			poll_s1 <= poll.data;
		end
	end

	always_comb begin
		pressed    = ~poll_s1.buttons_raw & BTN_MASK;
		up         = 1'b0;
		down       = 1'b0;
		cursor_nxt = cursor_q;
		unique case (pressed)
			BTN_UP:    up = 1'b1;
			BTN_DOWN:  down = 1'b1;
			BTN_RIGHT: if (cursor_q != CUR_YEAR) cursor_nxt = cursor_q + 3'd1;
			BTN_LEFT:  if (cursor_q != CUR_EXIT) cursor_nxt = cursor_q - 3'd1;
			default:   ;
		endcase
	end

	// Year is clamped into range before the step, then saturates at both ends
	always_comb begin
		year_clamp = poll_s1.cur_year;
		if (year_clamp < YEAR_BASE) year_clamp = YEAR_BASE;
		if (year_clamp > YEAR_TOP)  year_clamp = YEAR_TOP;
		year_new = year_clamp;
		if (up && year_clamp != YEAR_TOP)    year_new = year_clamp + 12'd1;
		if (down && year_clamp != YEAR_BASE) year_new = year_clamp - 12'd1;
		year_off = year_new - YEAR_BASE;
	end

	always_comb begin
		field_val = '0;
		unique case (cursor_nxt)
			CUR_SECONDS: field_val = {1'b0, up
				? ((poll_s1.cur_seconds < SEC_TOP) ? poll_s1.cur_seconds + 6'd1 : 6'd0)
				: ((poll_s1.cur_seconds > 6'd0) ? poll_s1.cur_seconds - 6'd1 : SEC_TOP)};
			CUR_MINUTES: field_val = {1'b0, up
				? ((poll_s1.cur_minutes < SEC_TOP) ? poll_s1.cur_minutes + 6'd1 : 6'd0)
				: ((poll_s1.cur_minutes > 6'd0) ? poll_s1.cur_minutes - 6'd1 : SEC_TOP)};
			CUR_HOURS: field_val = {2'b0, up
				? ((poll_s1.cur_hours < HOUR_TOP) ? poll_s1.cur_hours + 5'd1 : 5'd0)
				: ((poll_s1.cur_hours > 5'd0) ? poll_s1.cur_hours - 5'd1 : HOUR_TOP)};
			CUR_WEEKDAY: field_val = {4'b0, up
				? ((poll_s1.cur_weekday < WEEKDAY_TOP) ? poll_s1.cur_weekday + 3'd1 : 3'd1)
				: ((poll_s1.cur_weekday > 3'd1) ? poll_s1.cur_weekday - 3'd1 : WEEKDAY_TOP)};
			CUR_DAY: field_val = {2'b0, up
				? ((poll_s1.cur_day < DAY_TOP) ? poll_s1.cur_day + 5'd1 : 5'd1)
				: ((poll_s1.cur_day > 5'd1) ? poll_s1.cur_day - 5'd1 : DAY_TOP)};
			CUR_MONTH: field_val = {3'b0, up
				? ((poll_s1.cur_month < MONTH_TOP) ? poll_s1.cur_month + 4'd1 : 4'd1)
				: ((poll_s1.cur_month > 4'd1) ? poll_s1.cur_month - 4'd1 : MONTH_TOP)};
			CUR_YEAR: field_val = year_off[6:0];
			default:  field_val = '0;
		endcase
	end

	always_comb begin
		res                 = '0;
		res.cursor_position = cursor_nxt;
		if (up || down) begin
			if (cursor_nxt == CUR_EXIT) begin
				res.exit_request = 1'b1;
			end else begin
				res.write_strobe = 1'b1;
				res.write_index  = cursor_nxt - 3'd1;
				res.write_value  = field_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cursor_q <= CUR_EXIT;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) cursor_q <= cursor_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= res;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

endmodule

### bench/tb_rtc_field_setup_editor_top.sv
`timescale 1ns / 1ps

module tb_rtc_field_setup_editor_top;
	import rfse_pkg::*;

	localparam int RANDOM_POLLS = 1450;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 10;

	// raw pin patterns, active low
	localparam logic [3:0] KEY_UP    = BTN_MASK & ~BTN_UP;
	localparam logic [3:0] KEY_DOWN  = BTN_MASK & ~BTN_DOWN;
	localparam logic [3:0] KEY_LEFT  = BTN_MASK & ~BTN_LEFT;
	localparam logic [3:0] KEY_RIGHT = BTN_MASK & ~BTN_RIGHT;
	localparam logic [3:0] KEY_NONE  = BTN_MASK;
	localparam logic [3:0] KEY_ALL   = ~BTN_MASK;

	class clock_edit_scoreboard;
		logic [2:0]   cursor;
		rfse_result_t expected_results[$];
		int           errors;
		int           polls;
		int           checked;
		int           writes;
		int           exits;

		function new();
			cursor  = CUR_EXIT;
			errors  = 0;
			polls   = 0;
			checked = 0;
			writes  = 0;
			exits   = 0;
		endfunction

		function int wrap_step(int v, int top, int bottom, bit up);
			if (up)
				return (v < top) ? v + 1 : bottom;
			return (v > bottom) ? v - 1 : top;
		endfunction

		function int edited_value(rfse_poll_t p, bit up);
			int yr;
			case (cursor)
				CUR_SECONDS: return wrap_step(p.cur_seconds, SEC_TOP, 0, up);
				CUR_MINUTES: return wrap_step(p.cur_minutes, SEC_TOP, 0, up);
				CUR_HOURS:   return wrap_step(p.cur_hours, HOUR_TOP, 0, up);
				CUR_WEEKDAY: return wrap_step(p.cur_weekday, WEEKDAY_TOP, 1, up);
				CUR_DAY:     return wrap_step(p.cur_day, DAY_TOP, 1, up);
				CUR_MONTH:   return wrap_step(p.cur_month, MONTH_TOP, 1, up);
				default: begin
					// year saturates at both ends instead of wrapping
					yr = p.cur_year;
					if (yr < YEAR_BASE)
						yr = YEAR_BASE;
					if (yr > YEAR_TOP)
						yr = YEAR_TOP;
					if (up && yr < YEAR_TOP)
						yr++;
					else if (!up && yr > YEAR_BASE)
						yr--;
					return yr - YEAR_BASE;
				end
			endcase
		endfunction

		function rfse_result_t predict_edit(rfse_poll_t p);
			rfse_result_t r;
			logic [3:0]   pressed;
			bit           up;
			bit           down;
			int           v;
			pressed = ~p.buttons_raw & BTN_MASK;
			up      = (pressed == BTN_UP);
			down    = (pressed == BTN_DOWN);
			r       = '0;
			if (pressed == BTN_RIGHT && cursor < CUR_YEAR)
				cursor++;
			else if (pressed == BTN_LEFT && cursor > CUR_EXIT)
				cursor--;
			if (up || down) begin
				if (cursor == CUR_EXIT) begin
					r.exit_request = 1'b1;
				end else begin
					v = edited_value(p, up);
					r.write_strobe = 1'b1;
					r.write_index  = cursor - 3'd1;
					r.write_value  = v[6:0];
				end
			end
			r.cursor_position = cursor;
			return r;
		endfunction

		function void note_poll(rfse_poll_t p);
			polls++;
			expected_results.push_back(predict_edit(p));
		endfunction

		function bit field_ok(string name, logic [6:0] want, logic [6:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				return 0;
			end
			return 1;
		endfunction

		function void check_result(rfse_result_t got);
			rfse_result_t want;
			bit           ok;
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with none expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (want.write_strobe)
				writes++;
			if (want.exit_request)
				exits++;
			ok = field_ok("cursor_position", want.cursor_position, got.cursor_position);
			ok &= field_ok("write_strobe", want.write_strobe, got.write_strobe);
			ok &= field_ok("write_index", want.write_index, got.write_index);
			ok &= field_ok("write_value", want.write_value, got.write_value);
			ok &= field_ok("exit_request", want.exit_request, got.exit_request);
			if (!ok)
				errors++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   quiet;
	bit   burst;
	bit   hold_request;

	clock_edit_scoreboard sb;

	rfse_poll_if   poll_ch();
	rfse_result_if result_ch();

	rtc_field_setup_editor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("rtc_field_setup_editor_top regression: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rfse_poll_t rand_poll();
		rfse_poll_t p;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 20)
			p.buttons_raw = KEY_RIGHT;
		else if (r < 40)
			p.buttons_raw = KEY_LEFT;
		else if (r < 60)
			p.buttons_raw = KEY_UP;
		else if (r < 80)
			p.buttons_raw = KEY_DOWN;
		else
			p.buttons_raw = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 85) begin
			p.cur_seconds = 6'($urandom_range(0, 59));
			p.cur_minutes = 6'($urandom_range(0, 59));
			p.cur_hours   = 5'($urandom_range(0, 23));
			p.cur_weekday = 3'($urandom_range(1, 7));
			p.cur_day     = 5'($urandom_range(1, 31));
			p.cur_month   = 4'($urandom_range(1, 12));
			p.cur_year    = 12'($urandom_range(2000, 2099));
		end else begin
			// out-of-range readback, every bit free
			p.cur_seconds = 6'($urandom_range(0, 63));
			p.cur_minutes = 6'($urandom_range(0, 63));
			p.cur_hours   = 5'($urandom_range(0, 31));
			p.cur_weekday = 3'($urandom_range(0, 7));
			p.cur_day     = 5'($urandom_range(0, 31));
			p.cur_month   = 4'($urandom_range(0, 15));
			p.cur_year    = 12'($urandom_range(0, 4095));
		end
		return p;
	endfunction

	task automatic send_poll(rfse_poll_t p);
		int gap;
		poll_ch.valid <= 1'b1;
		poll_ch.data  <= p;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		sb.note_poll(p);
		gap = (quiet || burst) ? 0 : gap_len();
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// same value loaded into every clock field, truncated per width
	task automatic press(logic [3:0] raw, logic [11:0] v);
		rfse_poll_t p;
		p.buttons_raw = raw;
		p.cur_seconds = v[5:0];
		p.cur_minutes = v[5:0];
		p.cur_hours   = v[4:0];
		p.cur_weekday = v[2:0];
		p.cur_day     = v[4:0];
		p.cur_month   = v[3:0];
		p.cur_year    = v;
		send_poll(p);
	endtask

	task automatic drain_results();
		poll_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// result receiver with random stalls and the requested long hold-off
	initial begin
		int stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.data);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !quiet && $urandom_range(0, 99) < 15) begin
				stall = gap_len();
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		sb           = new();
		quiet        = 1'b0;
		burst        = 1'b0;
		hold_request = 1'b0;
		arst_n        <= 1'b0;
		poll_ch.valid <= 1'b0;
		poll_ch.data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: exit, saturation, wrap at the top of each field and at the bottom of seconds, weekday and day
		press(KEY_UP, 0);
		press(KEY_DOWN, 0);
		press(KEY_LEFT, 0);
		press(KEY_RIGHT, 59);
		press(KEY_UP, 59);
		press(KEY_DOWN, 0);
		press(KEY_UP, 63);
		press(KEY_RIGHT, 59);
		press(KEY_UP, 59);
		press(KEY_RIGHT, 23);
		press(KEY_UP, 23);
		press(KEY_DOWN, 31);
		press(KEY_RIGHT, 7);
		press(KEY_UP, 7);
		press(KEY_DOWN, 0);
		press(KEY_RIGHT, 31);
		press(KEY_UP, 31);
		press(KEY_DOWN, 1);
		press(KEY_RIGHT, 12);
		press(KEY_UP, 12);
		press(KEY_DOWN, 15);
		press(KEY_RIGHT, 2099);
		press(KEY_UP, 2099);
		press(KEY_DOWN, 2000);
		press(KEY_UP, 4095);
		press(KEY_DOWN, 0);
		press(KEY_RIGHT, 0);
		press(KEY_NONE, 0);
		press(KEY_ALL, 0);

		for (int i = 0; i < RANDOM_POLLS; i++) begin
			if (i == 400) begin
				// receiver holds off while polls keep coming, fills both stages
				hold_request = 1'b1;
				burst = 1'b1;
			end
			if (i == 460)
				burst = 1'b0;
			if (i == 800)
				drain_results();
			quiet = (i >= 1000 && i < 1100);
			send_poll(rand_poll());
		end
		quiet = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("polls sent %0d, results checked %0d, register writes %0d, exit requests %0d",
			sb.polls, sb.checked, sb.writes, sb.exits);
		$display("covered every field wrap, year clamp, cursor limits and back-pressure");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rtc_field_setup_editor_top regression: pass");
		end else begin
			$display("%0d failing transactions, %0d results missing", sb.errors, sb.pending());
			$display("rtc_field_setup_editor_top regression: fail");
		end
		$finish;
	end

endmodule
